[hw/rtl/cbpm_pkg.sv]
`default_nettype none
package cbpm_pkg;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_UNPIN    = 3'd2,
    OP_FLUSH    = 3'd3,
    OP_DISPOSE  = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ALL_PINNED = 3'd1;
  localparam logic [2:0] ST_NOT_PINNED = 3'd2;
  localparam logic [2:0] ST_PINNED     = 3'd3;
  localparam logic [2:0] ST_NOT_RES    = 3'd4;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_FETCH  = 2'd1;
  localparam logic [1:0] ACT_WBACK  = 2'd2;
  localparam logic [1:0] ACT_DELETE = 2'd3;

  localparam int MAX_ACTIVE = 16;
  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  // result beat
  typedef struct packed {
    logic [3:0]  frame;
    logic [2:0]  status;
    logic        hit;
    logic [1:0]  action;
    logic [7:0]  action_file;
    logic [31:0] action_page;
    logic        last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item, zero scan index
    logic lookup;     // register associative match result
    logic pin_hit;    // set refbit, add pin on matched frame
    logic unpin;      // remove pin on matched frame
    logic drop_match; // clear matched frame
    logic hand_step;  // advance hand, examine frame
    logic install;    // install new page into victim
    logic scan_step;  // advance flush scan index
    logic scan_clear; // clear frame at scan index
    logic scan_rst;   // restart flush scan at frame zero
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic match;
    logic match_pinned;
    logic sw_invalid;
    logic sw_ref;
    logic sw_pinned;
    logic sw_dirty;
    logic sweep_done;
    logic scan_hit;
    logic scan_pinned;
    logic scan_dirty;
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/cbpm_datapath.sv]
`default_nettype none
module cbpm_datapath #(
  parameter int NUM_FRAMES = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire [4:0]        cfg_n,
  input  wire              cfg_we,
  input  wire [2:0]        operation,
  input  wire [7:0]        file_id,
  input  wire [31:0]       page_no,
  input  wire              dirty_flag,
  input  cbpm_pkg::cmd_t   cmd,
  input  wire              ref_clr,
  output cbpm_pkg::stat_t  stat,
  output logic [2:0]       op_q,
  output logic [7:0]       fid_q,
  output logic [31:0]      pg_q,
  output logic [3:0]       match_idx,
  output logic [3:0]       hand_out,
  output logic [7:0]       hand_file,
  output logic [31:0]      hand_page,
  output logic [3:0]       scan_out,
  output logic [31:0]      scan_page
);
  localparam int CAP = (NUM_FRAMES < cbpm_pkg::MAX_ACTIVE) ? NUM_FRAMES :
                       cbpm_pkg::MAX_ACTIVE;
  localparam int IW = $clog2(NUM_FRAMES);

  logic [NUM_FRAMES-1:0] vld, refb, drt;
  logic [15:0]  pins [NUM_FRAMES];
  logic [7:0]   ffile [NUM_FRAMES];
  logic [31:0]  fpage [NUM_FRAMES];
  logic [4:0]   n_act;
  logic [4:0]   frames_in_use;
  logic [3:0]   hand;
  logic [3:0]   hand_nx;
  logic [3:0]   hand_mod;
  logic [8:0]   hred;
  logic [5:0]   sweep_cnt;
  logic [4:0]   scan;
  logic         dflag_q;
  logic         match_q;
  logic         match_pinned_q;
  logic [3:0]   midx;
  logic         mfound;
  logic [3:0]   victim;
  logic [IW-1:0] hi, mi, si, vi;

  // active count clamped to 1..CAP
  always_comb begin
    n_act = frames_in_use;
    if (n_act == 5'd0) n_act = 5'd1;
    if (n_act > 5'(CAP)) n_act = 5'(CAP);
  end

  // associative match over active frames, lowest index wins
  always_comb begin
    mfound = 1'b0;
    midx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (5'(i) < n_act && vld[i] && ffile[i] == fid_q && fpage[i] == pg_q) begin
        mfound = 1'b1;
        midx = 4'(i);
      end
    end
  end

  // hand modulo the active count, by shifted compare and subtract
  always_comb begin
    hred = 9'(hand);
    for (int k = 3; k >= 0; k--) begin
      if (hred >= (9'(n_act) << k)) hred = hred - (9'(n_act) << k);
    end
    hand_mod = hred[3:0];
  end

  assign hand_nx = (5'(hand) + 5'd1 >= n_act) ? 4'd0 : hand + 4'd1;
  assign hi = IW'(hand);
  assign mi = IW'(match_idx);
  assign si = IW'(scan[3:0]);
  assign vi = IW'(victim);

  // sweep status looks at frame under the registered hand
  assign stat.match        = match_q;
  assign stat.match_pinned = match_pinned_q;
  assign stat.sw_invalid  = !vld[hi];
  assign stat.sw_ref      = refb[hi];
  assign stat.sw_pinned   = pins[hi] != 16'd0;
  assign stat.sw_dirty    = drt[hi];
  assign stat.sweep_done  = sweep_cnt >= {n_act, 1'b0};
  assign stat.scan_hit    = vld[si] && ffile[si] == fid_q;
  assign stat.scan_pinned = pins[si] != 16'd0;
  assign stat.scan_dirty  = drt[si];
  assign stat.scan_done   = scan >= n_act;
  assign hand_out  = hand;
  assign hand_file = ffile[hi];
  assign hand_page = fpage[hi];
  assign scan_out  = scan[3:0];
  assign scan_page = fpage[si];

  // config register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 5'd16;
      hand <= 4'(CAP - 1);
      vld <= '0;
      refb <= '0;
      drt <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) pins[i] <= '0;
      match_q <= 1'b0;
      match_pinned_q <= 1'b0;
      sweep_cnt <= '0;
      scan <= '0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_n;
      end
      if (cmd.load) begin
        sweep_cnt <= '0;
        scan <= '0;
        // keep hand in the active range
        hand <= hand_mod;
      end
      if (cmd.lookup) begin
        match_q <= mfound;
        match_pinned_q <= pins[IW'(midx)] != 16'd0;
      end
      if (cmd.pin_hit) begin
        refb[mi] <= 1'b1;
        if (pins[mi] != cbpm_pkg::PIN_MAX) pins[mi] <= pins[mi] + 16'd1;
      end
      if (cmd.unpin) begin
        pins[mi] <= pins[mi] - 16'd1;
        if (dflag_q) drt[mi] <= 1'b1;
      end
      if (cmd.drop_match) begin
        vld[mi] <= 1'b0; refb[mi] <= 1'b0; drt[mi] <= 1'b0; pins[mi] <= '0;
      end
      if (cmd.hand_step) begin
        hand <= hand_nx;
        sweep_cnt <= sweep_cnt + 6'd1;
      end
      // second chance: clear refbit of the examined frame
      if (ref_clr) refb[hi] <= 1'b0;
      if (cmd.install) begin
        vld[vi] <= 1'b1; refb[vi] <= 1'b1; drt[vi] <= 1'b0; pins[vi] <= 16'd1;
      end
      if (cmd.scan_step) scan <= scan + 5'd1;
      if (cmd.scan_rst) scan <= '0;
      if (cmd.scan_clear) begin
        vld[si] <= 1'b0; refb[si] <= 1'b0; drt[si] <= 1'b0; pins[si] <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      fid_q <= file_id;
      pg_q <= page_no;
      dflag_q <= dirty_flag;
    end
    if (cmd.lookup) match_idx <= midx;
    if (cmd.install) begin
      ffile[vi] <= fid_q;
      fpage[vi] <= pg_q;
    end
    victim <= hand;
  end
endmodule
`default_nettype wire

[hw/rtl/cbpm_ctrl.sv]
`default_nettype none
module cbpm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output cbpm_pkg::result_t   res,
  output cbpm_pkg::cmd_t      cmd,
  input  cbpm_pkg::stat_t     stat,
  input  wire [2:0]           op_q,
  input  wire [7:0]           fid_q,
  input  wire [31:0]          pg_q,
  input  wire [3:0]           match_idx,
  input  wire [3:0]           hand_out,
  input  wire [7:0]           hand_file,
  input  wire [31:0]          hand_page,
  input  wire [3:0]           scan_out,
  input  wire [31:0]          scan_page,
  output logic                ref_clr
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOOK   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_STEP   = 9'b000001000,
    S_EXAM   = 9'b000010000,
    S_INST   = 9'b000100000,
    S_PCHK   = 9'b001000000,
    S_FSCAN  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;
  cbpm_pkg::result_t res_next;
  logic done, done_next;   // result in S_OUT is the final one

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    ref_clr = 1'b0;
    res_next = res;
    done_next = done;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        res_next = '0;
        res_next.last = 1'b1;
        done_next = 1'b1;
        state_next = S_OUT;
        case (op_q)
          cbpm_pkg::OP_READ, cbpm_pkg::OP_ALLOC: begin
            if (stat.match) begin
              cmd.pin_hit = 1'b1;
              res_next.frame = match_idx;
              res_next.hit = 1'b1;
            end else begin
              state_next = S_STEP;
            end
          end
          cbpm_pkg::OP_UNPIN: begin
            if (!stat.match) begin
              res_next.status = cbpm_pkg::ST_NOT_RES;
            end else if (!stat.match_pinned) begin
              res_next.frame = match_idx;
              res_next.status = cbpm_pkg::ST_NOT_PINNED;
              res_next.hit = 1'b1;
            end else begin
              cmd.unpin = 1'b1;
              res_next.frame = match_idx;
              res_next.hit = 1'b1;
            end
          end
          cbpm_pkg::OP_FLUSH: state_next = S_PCHK;
          cbpm_pkg::OP_DISPOSE: begin
            if (stat.match) begin
              cmd.drop_match = 1'b1;
              res_next.frame = match_idx;
              res_next.hit = 1'b1;
            end
            res_next.action = cbpm_pkg::ACT_DELETE;
            res_next.action_file = fid_q;
            res_next.action_page = pg_q;
          end
          default: ;
        endcase
      end
      // advance the hand, or end the sweep with all pinned once it is done
      S_STEP: begin
        if (stat.sweep_done) begin
          res_next = '0;
          res_next.status = cbpm_pkg::ST_ALL_PINNED;
          res_next.last = 1'b1;
          done_next = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.hand_step = 1'b1;
          state_next = S_EXAM;
        end
      end
      // examine frame under the hand
      S_EXAM: begin
        if (stat.sw_invalid) begin
          state_next = S_INST;
        end else if (stat.sw_ref) begin
          ref_clr = 1'b1;
          state_next = S_STEP;
        end else if (stat.sw_pinned) begin
          state_next = S_STEP;
        end else if (stat.sw_dirty) begin
          res_next = '0;
          res_next.frame = hand_out;
          res_next.action = cbpm_pkg::ACT_WBACK;
          res_next.action_file = hand_file;
          res_next.action_page = hand_page;
          done_next = 1'b0;
          state_next = S_OUT;
        end else begin
          state_next = S_INST;
        end
      end
      S_INST: begin
        cmd.install = 1'b1;
        res_next = '0;
        res_next.frame = hand_out;
        res_next.last = 1'b1;
        if (op_q == cbpm_pkg::OP_READ) begin
          res_next.action = cbpm_pkg::ACT_FETCH;
          res_next.action_file = fid_q;
          res_next.action_page = pg_q;
        end
        done_next = 1'b1;
        state_next = S_OUT;
      end
      // flush: pinned check pass
      S_PCHK: begin
        if (stat.scan_done) begin
          state_next = S_FSCAN;
          cmd.scan_rst = 1'b1;
        end else if (stat.scan_hit && stat.scan_pinned) begin
          res_next = '0;
          res_next.frame = scan_out;
          res_next.status = cbpm_pkg::ST_PINNED;
          res_next.last = 1'b1;
          done_next = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      // flush: write-back and clear pass
      S_FSCAN: begin
        if (stat.scan_done) begin
          res_next = '0;
          res_next.last = 1'b1;
          done_next = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_hit) begin
            cmd.scan_clear = 1'b1;
            if (stat.scan_dirty) begin
              res_next = '0;
              res_next.frame = scan_out;
              res_next.action = cbpm_pkg::ACT_WBACK;
              res_next.action_file = fid_q;
              res_next.action_page = scan_page;
              done_next = 1'b0;
              state_next = S_OUT;
            end
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (done) state_next = S_IDLE;
          else if (op_q == cbpm_pkg::OP_FLUSH) state_next = S_FSCAN;
          else state_next = S_INST;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end
endmodule
`default_nettype wire

[hw/rtl/clock_buffer_pool_manager_top.sv]
`default_nettype none
// Clock-replacement buffer pool tag manager. One item is handled at a time and
// in_ready is high only while idle. A hit, unpin, dispose or unknown operation
// is decided after the lookup and gives one result beat. On a miss the clock
// hand steps and examines one frame at a time (at most 2*active frames), then
// the page is installed; when every frame is pinned the sweep ends with an
// all-pinned result. A flush runs a pinned check pass over the active frames,
// then a write-back and clear pass, with one beat per dirty frame and a final
// beat. The sweep/scan sequencer sets the pace; receiver stalls hold each
// beat. Each result beat is held in an output register until taken; last
// marks the final beat of an item.
module clock_buffer_pool_manager_top #(
  parameter int NUM_FRAMES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [4:0]   frames_in_use,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [2:0]   operation,
  input  wire [7:0]   file_id,
  input  wire [31:0]  page_no,
  input  wire         dirty_flag,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  frame,
  output logic [2:0]  status,
  output logic        hit,
  output logic [1:0]  action,
  output logic [7:0]  action_file,
  output logic [31:0] action_page,
  output logic        last
);
  cbpm_pkg::cmd_t    cmd;
  cbpm_pkg::stat_t   stat;
  cbpm_pkg::result_t res;
  logic [2:0]  op_q;
  logic [7:0]  fid_q;
  logic [31:0] pg_q, hand_page, scan_page;
  logic [3:0]  match_idx, hand_out, scan_out;
  logic [7:0]  hand_file;
  logic        ref_clr;

  assign cfg_ready = 1'b1;

  cbpm_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
    .clk, .rst,
    .cfg_n(frames_in_use), .cfg_we(cfg_valid),
    .operation, .file_id, .page_no, .dirty_flag,
    .cmd, .ref_clr, .stat, .op_q, .fid_q, .pg_q, .match_idx,
    .hand_out, .hand_file, .hand_page, .scan_out, .scan_page
  );

  cbpm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .res, .cmd, .stat, .op_q, .fid_q, .pg_q, .match_idx,
    .hand_out, .hand_file, .hand_page, .scan_out, .scan_page, .ref_clr
  );

  assign frame = res.frame;
  assign status = res.status;
  assign hit = res.hit;
  assign action = res.action;
  assign action_file = res.action_file;
  assign action_page = res.action_page;
  assign last = res.last;

  // no new item while a result beat is pending
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  // action none carries no page
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == cbpm_pkg::ACT_NONE) |-> (action_page == 32'd0))
    else $error("stray action page");
endmodule
`default_nettype wire

[tb/clock_buffer_pool_manager_top_tb.sv]
`timescale 1ns / 100ps

module clock_buffer_pool_manager_top_tb;

  localparam int NFR = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  fid;
    logic [31:0] pg;
    logic        df;
  } page_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  frames_in_use = 5'd16;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = 3'd0;
  logic [7:0]  file_id = 8'd0;
  logic [31:0] page_no = 32'd0;
  logic        dirty_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  frame;
  logic [2:0]  status;
  logic        hit;
  logic [1:0]  action;
  logic [7:0]  action_file;
  logic [31:0] action_page;
  logic        last;

  clock_buffer_pool_manager_top #(.NUM_FRAMES(NFR)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .frames_in_use(frames_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .file_id(file_id), .page_no(page_no), .dirty_flag(dirty_flag),
    .out_valid(out_valid), .out_ready(out_ready), .frame(frame), .status(status),
    .hit(hit), .action(action), .action_file(action_file),
    .action_page(action_page), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pool shadow state
  logic [4:0]  pool_size;
  logic        pool_valid [NFR];
  logic [7:0]  pool_file [NFR];
  logic [31:0] pool_page [NFR];
  logic [15:0] pool_pins [NFR];
  logic        pool_ref [NFR];
  logic        pool_dirty [NFR];
  int          hand;

  page_req_t pending_reqs[$];
  cbpm_pkg::result_t expected_beats[$];
  int        errors = 0;
  int        cycles = 0;
  int        hold_req = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int active_frames();
    if (pool_size < 1) return 1;
    if (pool_size > NFR) return NFR;
    return int'(pool_size);
  endfunction

  function automatic void push_beat(int fr, logic [2:0] st, logic h, logic [1:0] act,
                                    logic [7:0] af, logic [31:0] ap, logic lst);
    cbpm_pkg::result_t r;
    r.frame = fr[3:0];
    r.status = st;
    r.hit = h;
    r.action = act;
    r.action_file = (act == cbpm_pkg::ACT_NONE) ? 8'd0 : af;
    r.action_page = (act == cbpm_pkg::ACT_NONE) ? 32'd0 : ap;
    r.last = lst;
    expected_beats.push_back(r);
  endfunction

  function automatic void drop_frame(int i);
    pool_valid[i] = 1'b0;
    pool_pins[i] = '0;
    pool_ref[i] = 1'b0;
    pool_dirty[i] = 1'b0;
  endfunction

  function automatic int find_tag(int n, logic [7:0] fid, logic [31:0] pg);
    for (int i = 0; i < n; i++)
      if (pool_valid[i] && pool_file[i] == fid && pool_page[i] == pg) return i;
    return -1;
  endfunction

  // two-round clock sweep; -1 when every frame is pinned
  function automatic int pick_victim(int n);
    for (int i = 0; i < 2 * n; i++) begin
      hand = (hand + 1) % n;
      if (!pool_valid[hand]) return hand;
      if (pool_ref[hand]) begin
        pool_ref[hand] = 1'b0;
        continue;
      end
      if (pool_pins[hand] != 0) continue;
      if (pool_dirty[hand])
        push_beat(hand, cbpm_pkg::ST_OK, 1'b0, cbpm_pkg::ACT_WBACK, pool_file[hand],
                  pool_page[hand], 1'b0);
      drop_frame(hand);
      return hand;
    end
    return -1;
  endfunction

  function automatic void predict_pool(page_req_t q);
    int n;
    int f;
    n = active_frames();
    case (q.op)
      cbpm_pkg::OP_READ, cbpm_pkg::OP_ALLOC: begin
        f = find_tag(n, q.fid, q.pg);
        if (f >= 0) begin
          pool_ref[f] = 1'b1;
          if (pool_pins[f] != cbpm_pkg::PIN_MAX) pool_pins[f]++;
          push_beat(f, cbpm_pkg::ST_OK, 1'b1, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        end else begin
          f = pick_victim(n);
          if (f < 0)
            push_beat(0, cbpm_pkg::ST_ALL_PINNED, 1'b0, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
          else begin
            pool_valid[f] = 1'b1;
            pool_file[f] = q.fid;
            pool_page[f] = q.pg;
            pool_pins[f] = 16'd1;
            pool_ref[f] = 1'b1;
            pool_dirty[f] = 1'b0;
            push_beat(f, cbpm_pkg::ST_OK, 1'b0,
                      (q.op == cbpm_pkg::OP_READ) ? cbpm_pkg::ACT_FETCH : cbpm_pkg::ACT_NONE,
                      q.fid, q.pg, 1'b1);
          end
        end
      end
      cbpm_pkg::OP_UNPIN: begin
        f = find_tag(n, q.fid, q.pg);
        if (f < 0)
          push_beat(0, cbpm_pkg::ST_NOT_RES, 1'b0, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        else if (pool_pins[f] == 0)
          push_beat(f, cbpm_pkg::ST_NOT_PINNED, 1'b1, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        else begin
          pool_pins[f]--;
          if (q.df) pool_dirty[f] = 1'b1;
          push_beat(f, cbpm_pkg::ST_OK, 1'b1, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        end
      end
      cbpm_pkg::OP_FLUSH: begin
        f = -1;
        for (int i = 0; i < n; i++)
          if (f < 0 && pool_valid[i] && pool_file[i] == q.fid && pool_pins[i] != 0) f = i;
        if (f >= 0)
          push_beat(f, cbpm_pkg::ST_PINNED, 1'b0, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        else begin
          for (int i = 0; i < n; i++)
            if (pool_valid[i] && pool_file[i] == q.fid) begin
              if (pool_dirty[i])
                push_beat(i, cbpm_pkg::ST_OK, 1'b0, cbpm_pkg::ACT_WBACK, q.fid,
                          pool_page[i], 1'b0);
              drop_frame(i);
            end
          push_beat(0, cbpm_pkg::ST_OK, 1'b0, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
        end
      end
      cbpm_pkg::OP_DISPOSE: begin
        f = find_tag(n, q.fid, q.pg);
        if (f >= 0) drop_frame(f);
        push_beat((f >= 0) ? f : 0, cbpm_pkg::ST_OK, f >= 0, cbpm_pkg::ACT_DELETE,
                  q.fid, q.pg, 1'b1);
      end
      default: push_beat(0, cbpm_pkg::ST_OK, 1'b0, cbpm_pkg::ACT_NONE, 8'd0, 32'd0, 1'b1);
    endcase
  endfunction

  // sender: bursts and gaps, payload held until accepted
  int burst_left = 5;
  int gap_left = 0;
  always @(posedge clk) begin
    page_req_t q;
    if (in_valid && in_ready) begin
      q.op = operation;
      q.fid = file_id;
      q.pg = page_no;
      q.df = dirty_flag;
      predict_pool(q);
    end
    if (!(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        operation <= q.op;
        file_id <= q.fid;
        page_no <= q.pg;
        dirty_flag <= q.df;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus requested long hold-offs
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (cycles % 150 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_mode == 0) out_ready <= 1'b1;
    else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 1) != 0);
  end

  // result checker
  always @(posedge clk) begin
    cbpm_pkg::result_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", 32'(frame), 32'd0);
      end else begin
        w = expected_beats.pop_front();
        if (frame !== w.frame) report("frame", 32'(frame), 32'(w.frame));
        if (status !== w.status) report("status", 32'(status), 32'(w.status));
        if (hit !== w.hit) report("hit", 32'(hit), 32'(w.hit));
        if (action !== w.action) report("action", 32'(action), 32'(w.action));
        if (action_file !== w.action_file)
          report("action_file", 32'(action_file), 32'(w.action_file));
        if (action_page !== w.action_page) report("action_page", action_page, w.action_page);
        if (last !== w.last) report("last", 32'(last), 32'(w.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void add_req(logic [2:0] op, logic [7:0] fid, logic [31:0] pg, logic df);
    page_req_t q;
    q.op = op;
    q.fid = fid;
    q.pg = pg;
    q.df = df;
    pending_reqs.push_back(q);
  endfunction

  // mostly well-formed traffic on a small tag set, some noise
  function automatic void add_random(int count);
    logic [7:0]  fid;
    logic [31:0] pg;
    int          sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      fid = (sel == 0) ? 8'($urandom) : ((sel == 1) ? 8'hFF : 8'($urandom_range(0, 2)));
      sel = $urandom_range(0, 9);
      pg = (sel == 0) ? $urandom : ((sel == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 4)));
      sel = $urandom_range(0, 99);
      if (sel < 40) add_req(cbpm_pkg::OP_READ, fid, pg, 1'($urandom));
      else if (sel < 48) add_req(cbpm_pkg::OP_ALLOC, fid, pg, 1'($urandom));
      else if (sel < 82) add_req(cbpm_pkg::OP_UNPIN, fid, pg, 1'($urandom));
      else if (sel < 89) add_req(cbpm_pkg::OP_FLUSH, fid, pg, 1'($urandom));
      else if (sel < 97) add_req(cbpm_pkg::OP_DISPOSE, fid, pg, 1'($urandom));
      else add_req(3'($urandom_range(5, 7)), fid, pg, 1'($urandom));
    end
  endfunction

  task automatic wait_drained();
    while (!(pending_reqs.size() == 0 && !in_valid && expected_beats.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [4:0] v);
    cfg_valid <= 1'b1;
    frames_in_use <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    pool_size = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    pool_size = 5'd16;
    for (int i = 0; i < NFR; i++) begin
      drop_frame(i);
      pool_file[i] = '0;
      pool_page[i] = '0;
    end
    hand = NFR - 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two-frame pool walks through every case
    write_pool_size(5'd2);
    add_req(cbpm_pkg::OP_READ, 8'h00, 32'h0, 1'b0);
    add_req(cbpm_pkg::OP_READ, 8'h00, 32'h0, 1'b0);
    add_req(cbpm_pkg::OP_ALLOC, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_req(cbpm_pkg::OP_READ, 8'h01, 32'h5, 1'b0);          // every frame pinned
    add_req(cbpm_pkg::OP_UNPIN, 8'h00, 32'h0, 1'b1);
    add_req(cbpm_pkg::OP_UNPIN, 8'h00, 32'h0, 1'b0);
    add_req(cbpm_pkg::OP_UNPIN, 8'h00, 32'h0, 1'b0);         // already unpinned
    add_req(cbpm_pkg::OP_UNPIN, 8'h09, 32'h9, 1'b0);         // not resident
    add_req(cbpm_pkg::OP_READ, 8'h01, 32'h5, 1'b0);          // dirty victim written back
    add_req(cbpm_pkg::OP_FLUSH, 8'h01, 32'h0, 1'b0);         // refused, page pinned
    add_req(cbpm_pkg::OP_UNPIN, 8'h01, 32'h5, 1'b1);
    add_req(cbpm_pkg::OP_FLUSH, 8'h01, 32'h0, 1'b0);         // write-back then clear
    add_req(cbpm_pkg::OP_ALLOC, 8'h01, 32'h5, 1'b0);
    add_req(cbpm_pkg::OP_ALLOC, 8'h01, 32'h5, 1'b0);         // resident allocate acts as hit
    add_req(cbpm_pkg::OP_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 1'b0);  // pinned page dropped
    add_req(cbpm_pkg::OP_DISPOSE, 8'h07, 32'h7, 1'b0);
    add_req(3'd5, 8'hAA, 32'h5555_5555, 1'b1);
    add_req(3'd6, 8'h55, 32'hAAAA_AAAA, 1'b0);
    add_req(3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_req(cbpm_pkg::OP_FLUSH, 8'hC8, 32'h0, 1'b0);
    wait_drained();

    // full pool, long receiver hold-off while the sender keeps offering
    write_pool_size(5'd16);
    add_random(90);
    hold_req++;
    wait_drained();

    write_pool_size(5'd0);
    add_random(15);
    wait_drained();

    write_pool_size(5'd3);
    add_random(60);
    wait_drained();

    write_pool_size(5'd31);
    add_random(50);
    wait_drained();

    write_pool_size(5'd7);
    add_random(35);
    hold_req++;
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[clock_buffer_pool_manager_top.f]
hw/rtl/cbpm_pkg.sv
hw/rtl/cbpm_datapath.sv
hw/rtl/cbpm_ctrl.sv
hw/rtl/clock_buffer_pool_manager_top.sv
tb/clock_buffer_pool_manager_top_tb.sv
